### src/mbs_pkg.sv
// ============================================================================
// Modbus TCP server package
// Shared widths, function codes, exception codes and state types.
// ============================================================================
package mbs_pkg;

    localparam int RX_W    = 8;
    localparam int CHUNK_W = 64;
    localparam int COUNT_W = 4;

    // Function codes
    localparam logic [7:0] FN_RD_COILS = 8'h01;
    localparam logic [7:0] FN_RD_DISC  = 8'h02;
    localparam logic [7:0] FN_RD_HOLD  = 8'h03;
    localparam logic [7:0] FN_RD_INPUT = 8'h04;
    localparam logic [7:0] FN_WR_COIL  = 8'h05;
    localparam logic [7:0] FN_WR_REG   = 8'h06;
    localparam logic [7:0] FN_WR_COILS = 8'h0F;
    localparam logic [7:0] FN_WR_REGS  = 8'h10;

    // Exception codes
    localparam logic [7:0] EXC_ILLEGAL_FN   = 8'h01;
    localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'h02;
    localparam logic [7:0] EXC_FLAG         = 8'h80;

    localparam logic [15:0] COIL_ON = 16'hFF00;
    localparam logic [7:0]  UNIT_ID = 8'h01;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_RX    = 6'b000010,
        S_CHECK = 6'b000100,
        S_WRITE = 6'b001000,
        S_HDR   = 6'b010000,
        S_BODY  = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        K_EXC   = 3'd0,
        K_RDREG = 3'd1,
        K_RDBIT = 3'd2,
        K_ECHO  = 3'd3,
        K_WRM   = 3'd4
    } t_kind;

endpackage

### src/mbs_ifs.sv
// ============================================================================
// Modbus TCP server channels
// Valid/ready channels for the received byte stream and the reply chunks.
// ============================================================================
interface mbs_rx_if import mbs_pkg::*;;
    logic            valid;
    logic            ready;
    logic [RX_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mbs_tx_if import mbs_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CHUNK_W-1:0] tx_chunk;
    logic [COUNT_W-1:0] tx_count;
    logic               tx_last;

    modport source (output valid, output tx_chunk, output tx_count, output tx_last,
                    input ready);
    modport sink   (input valid, input tx_chunk, input tx_count, input tx_last,
                    output ready);
endinterface

### src/modbus_tcp_register_server.sv
// ============================================================================
// Modbus TCP register server
// Frames an incoming TCP byte stream, serves holding registers and coils from
// on-chip memories and returns the reply in chunks of up to eight bytes.
// ============================================================================
// After reset the block clears the register and coil memories and accepts no
// byte meanwhile. While receiving it takes one byte per cycle. After the last
// byte of an accepted frame (protocol zero, non-empty PDU) it stops taking
// bytes until the reply has been handed to the packer: a decode step, a write
// for a single write or a PDU read and a write per data byte or coil of a
// multiple write, the seven header bytes, then the body: fixed reply bytes,
// each echoed byte after a PDU read, each register as a read and its two
// bytes, each status byte after eight coil reads. Reads are registered.
// A stalled output holds the sequencer only when a chunk is complete.
module modbus_tcp_register_server import mbs_pkg::*; #(
    parameter int REG_COUNT = 65536,
    parameter int MAX_REGS  = 125,
    parameter int PDU_BYTES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mbs_rx_if.sink    i_rx,
    mbs_tx_if.source  o_tx
);

    localparam int AW       = $clog2(REG_COUNT);
    localparam int PW       = $clog2(PDU_BYTES);
    localparam int FW       = $clog2(PDU_BYTES + 1);
    localparam int MAX_BITS = MAX_REGS * 8;

    t_state r_state, n_state;
    t_kind  r_kind;

    logic [AW-1:0] r_clr;
    logic [15:0]   r_tid, r_proto, r_flen;
    logic [16:0]   r_pos;
    logic [FW-1:0] r_fill, r_size;
    logic [7:0]    r_hdr [6];

    logic [7:0]  r_pdu_mem  [PDU_BYTES];
    logic [15:0] r_hold_mem [REG_COUNT];
    logic        r_coil_mem [REG_COUNT];
    logic [7:0]  r_pq;
    logic [15:0] r_hq;
    logic        r_cq;

    logic [7:0]  r_code, r_nb, r_hi, r_acc;
    logic [8:0]  r_plen, r_bcnt;
    logic [15:0] r_lim, r_ptr;
    logic [3:0]  r_ph;
    logic        r_bvld;

    logic [63:0] r_pk, r_oc;
    logic [2:0]  r_pkn;
    logic        r_ov, r_olast;
    logic [3:0]  r_ocnt;

    // Receive side
    logic          rx_fire, store, frame_end, go;
    logic [7:0]    b;
    logic [15:0]   fl_eff;
    logic [FW-1:0] fill_eff;

    assign rx_fire    = i_rx.valid && i_rx.ready;
    assign i_rx.ready = (r_state == S_RX);
    assign b          = i_rx.rx_byte;
    assign fl_eff     = (r_pos == 17'd5) ? {r_flen[7:0], b} : r_flen;
    assign store      = (r_pos >= 17'd7) && (r_fill < FW'(PDU_BYTES));
    assign fill_eff   = store ? r_fill + 1'b1 : r_fill;
    assign frame_end  = (r_pos >= 17'd5) && (r_pos >= ({1'b0, fl_eff} + 17'd5));
    assign go         = frame_end && (r_proto == 16'd0) && (fill_eff != '0);

    // PDU fields
    logic [7:0]  fn, bc;
    logic [15:0] addr_w, cnt_w;
    logic        is_reg;
    assign fn     = r_hdr[0];
    assign addr_w = {r_hdr[1], r_hdr[2]};
    assign cnt_w  = {r_hdr[3], r_hdr[4]};
    assign bc     = r_hdr[5];
    assign is_reg = (fn == FN_WR_REGS);

    // Request checks
    logic [16:0] sum17, nb17;
    logic        known, range_ok, rdreg_ok, rdbit_ok, wrm_ok;
    logic [9:0]  need_size;
    t_kind       c_kind;
    logic [7:0]  c_code;
    logic [8:0]  c_plen;

    always_comb begin
        known = (fn == FN_RD_COILS) || (fn == FN_RD_DISC) || (fn == FN_RD_HOLD) ||
                (fn == FN_RD_INPUT) || (fn == FN_WR_COIL) || (fn == FN_WR_REG) ||
                (fn == FN_WR_COILS) || (fn == FN_WR_REGS);
        sum17     = {1'b0, addr_w} + {1'b0, cnt_w};
        nb17      = ({1'b0, cnt_w} + 17'd7) >> 3;
        range_ok  = ({1'b0, sum17} <= 18'(REG_COUNT));
        rdreg_ok  = (cnt_w != 16'd0) && (cnt_w <= 16'(MAX_REGS)) && range_ok;
        rdbit_ok  = (cnt_w != 16'd0) && (cnt_w <= 16'(MAX_BITS)) && range_ok;
        need_size = 10'd6 + {2'b0, bc};
        wrm_ok    = (r_size >= FW'(6)) && (cnt_w != 16'd0) && range_ok &&
                    ({1'b0, 9'(r_size)} >= need_size) &&
                    (is_reg ? ((cnt_w <= 16'(MAX_REGS)) && ({8'd0, bc} == {cnt_w[14:0], 1'b0}))
                            : ({9'd0, bc} == nb17));
        c_kind = K_EXC;
        c_code = EXC_ILLEGAL_ADDR;
        c_plen = 9'd3;
        priority if (!known) begin
            c_code = EXC_ILLEGAL_FN;
        end else if (r_size < FW'(5)) begin
            c_kind = K_EXC;
        end else if ((fn == FN_RD_HOLD) || (fn == FN_RD_INPUT)) begin
            if (rdreg_ok) begin
                c_kind = K_RDREG;
                c_plen = 9'd3 + {cnt_w[7:0], 1'b0};
            end
        end else if ((fn == FN_RD_COILS) || (fn == FN_RD_DISC)) begin
            if (rdbit_ok) begin
                c_kind = K_RDBIT;
                c_plen = 9'd3 + {1'b0, nb17[7:0]};
            end
        end else if ((fn == FN_WR_COIL) || (fn == FN_WR_REG)) begin
            if ({1'b0, addr_w} < 17'(REG_COUNT)) begin
                c_kind = K_ECHO;
                c_plen = 9'(r_size) + 9'd1;
            end
        end else begin
            if (wrm_ok) begin
                c_kind = K_WRM;
                c_plen = 9'd6;
            end
        end
    end

    // Sequencer datapath
    logic        emit, adv, last, flush, byte_ready, wr_done;
    logic [7:0]  ebyte;
    logic [2:0]  j;
    logic [8:0]  jb;
    logic        hr_en, cr_en, pr_en, hw_en, cw_en, cw_data;
    logic [AW-1:0] hr_addr, cr_addr, hw_addr, cw_addr;
    logic [15:0] hw_data, a_ptr, a_half, off;
    logic [PW-1:0] pr_addr;

    assign jb      = r_bcnt - 9'd7;
    assign j       = jb[2:0];
    assign last    = (r_bcnt == r_plen + 9'd5);
    assign a_ptr   = addr_w + r_ptr;
    assign a_half  = addr_w + {1'b0, r_ptr[15:1]};
    assign off     = 16'd6 + (is_reg ? r_ptr : (r_ptr >> 3));
    assign wr_done = (r_ptr == r_lim - 16'd1);

    always_comb begin
        emit    = 1'b0;
        ebyte   = 8'd0;
        hr_en   = 1'b0;
        cr_en   = 1'b0;
        pr_en   = 1'b0;
        hw_en   = 1'b0;
        cw_en   = 1'b0;
        hr_addr = a_ptr[AW-1:0];
        cr_addr = a_ptr[AW-1:0];
        pr_addr = off[PW-1:0];
        hw_addr = r_clr;
        cw_addr = r_clr;
        hw_data = 16'd0;
        cw_data = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                hw_en = 1'b1;
                cw_en = 1'b1;
            end
            S_WRITE: begin
                if (r_kind == K_ECHO) begin
                    hw_addr = addr_w[AW-1:0];
                    cw_addr = addr_w[AW-1:0];
                    hw_data = cnt_w;
                    cw_data = (cnt_w == COIL_ON);
                    hw_en   = (fn == FN_WR_REG);
                    cw_en   = (fn != FN_WR_REG);
                end else if (r_ph == 4'd0) begin
                    pr_en = 1'b1;
                end else begin
                    hw_addr = a_half[AW-1:0];
                    hw_data = {r_hi, r_pq};
                    cw_addr = a_ptr[AW-1:0];
                    cw_data = r_pq[r_ptr[2:0]];
                    hw_en   = is_reg && r_ptr[0];
                    cw_en   = !is_reg;
                end
            end
            S_HDR: begin
                emit = 1'b1;
                case (r_bcnt[2:0])
                    3'd0:    ebyte = r_tid[15:8];
                    3'd1:    ebyte = r_tid[7:0];
                    3'd2:    ebyte = 8'd0;
                    3'd3:    ebyte = 8'd0;
                    3'd4:    ebyte = {7'd0, r_plen[8]};
                    3'd5:    ebyte = r_plen[7:0];
                    default: ebyte = UNIT_ID;
                endcase
            end
            S_BODY: begin
                unique case (r_kind)
                    K_EXC: begin
                        emit  = 1'b1;
                        ebyte = (j == 3'd0) ? (fn | EXC_FLAG) : r_code;
                    end
                    K_WRM: begin
                        emit = 1'b1;
                        case (j)
                            3'd0:    ebyte = fn;
                            3'd1:    ebyte = addr_w[15:8];
                            3'd2:    ebyte = addr_w[7:0];
                            3'd3:    ebyte = cnt_w[15:8];
                            default: ebyte = cnt_w[7:0];
                        endcase
                    end
                    K_ECHO: begin
                        pr_addr = r_ptr[PW-1:0];
                        if (r_ph == 4'd0) begin
                            pr_en = 1'b1;
                        end else begin
                            emit  = 1'b1;
                            ebyte = r_pq;
                        end
                    end
                    K_RDREG: begin
                        if (r_bcnt == 9'd7) begin
                            emit  = 1'b1;
                            ebyte = fn;
                        end else if (r_bcnt == 9'd8) begin
                            emit  = 1'b1;
                            ebyte = {cnt_w[6:0], 1'b0};
                        end else if (r_ph == 4'd0) begin
                            hr_en = 1'b1;
                        end else begin
                            emit  = 1'b1;
                            ebyte = (r_ph == 4'd1) ? r_hq[15:8] : r_hq[7:0];
                        end
                    end
                    default: begin
                        if (r_bcnt == 9'd7) begin
                            emit  = 1'b1;
                            ebyte = fn;
                        end else if (r_bcnt == 9'd8) begin
                            emit  = 1'b1;
                            ebyte = r_nb;
                        end else if (r_ph <= 4'd7) begin
                            cr_en = 1'b1;
                        end else if (r_ph == 4'd9) begin
                            emit  = 1'b1;
                            ebyte = r_acc;
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    assign flush      = (r_pkn == 3'd7) || last;
    assign byte_ready = !flush || !r_ov || o_tx.ready;
    assign adv        = !emit || byte_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == AW'(REG_COUNT - 1)) n_state = S_RX;
            S_RX:    if (rx_fire && go) n_state = S_CHECK;
            S_CHECK: begin
                if ((c_kind == K_ECHO) || (c_kind == K_WRM)) n_state = S_WRITE;
                else n_state = S_HDR;
            end
            S_WRITE: begin
                if ((r_kind == K_ECHO) || ((r_ph != 4'd0) && wr_done)) n_state = S_HDR;
            end
            S_HDR:   if (adv && (r_bcnt == 9'd6)) n_state = S_BODY;
            S_BODY:  if (emit && adv && last) n_state = S_RX;
            default: n_state = S_CLEAR;
        endcase
    end

    // Control and frame registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_tid   <= '0;
            r_proto <= '0;
            r_flen  <= '0;
            r_pos   <= '0;
            r_fill  <= '0;
            r_bcnt  <= '0;
            r_ptr   <= '0;
            r_ph    <= '0;
            r_acc   <= '0;
            r_kind  <= K_EXC;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (rx_fire) begin
                if (r_pos <= 17'd1) r_tid <= {r_tid[7:0], b};
                if ((r_pos == 17'd2) || (r_pos == 17'd3)) r_proto <= {r_proto[7:0], b};
                if (((r_pos == 17'd4) || (r_pos == 17'd5)) && !frame_end)
                    r_flen <= {r_flen[7:0], b};
                if (store && (r_fill < FW'(6))) r_hdr[r_fill[2:0]] <= b;
                if (frame_end) begin
                    r_pos   <= '0;
                    r_fill  <= '0;
                    r_proto <= '0;
                    r_flen  <= '0;
                    r_size  <= fill_eff;
                end else begin
                    r_pos  <= r_pos + 17'd1;
                    r_fill <= fill_eff;
                end
            end
            if (emit && adv) r_bcnt <= r_bcnt + 9'd1;
            unique case (r_state)
                S_CHECK: begin
                    r_kind <= c_kind;
                    r_code <= c_code;
                    r_plen <= c_plen;
                    r_nb   <= nb17[7:0];
                    r_lim  <= is_reg ? {cnt_w[14:0], 1'b0} : cnt_w;
                    r_bcnt <= '0;
                    r_ptr  <= '0;
                    r_ph   <= '0;
                end
                S_WRITE: begin
                    if (r_kind == K_WRM) begin
                        if (r_ph == 4'd0) begin
                            r_ph <= 4'd1;
                        end else begin
                            if (!r_ptr[0]) r_hi <= r_pq;
                            r_ptr <= r_ptr + 16'd1;
                            r_ph  <= 4'd0;
                        end
                    end
                end
                S_HDR: begin
                    r_ptr <= '0;
                    r_ph  <= '0;
                    r_acc <= '0;
                end
                S_BODY: begin
                    if (r_bcnt >= 9'd9 || r_kind == K_ECHO) begin
                        unique case (r_kind)
                            K_ECHO: begin
                                if (r_ph == 4'd0) begin
                                    r_ph <= 4'd1;
                                end else if (adv) begin
                                    r_ph  <= 4'd0;
                                    r_ptr <= r_ptr + 16'd1;
                                end
                            end
                            K_RDREG: begin
                                if (adv) begin
                                    if (r_ph == 4'd2) begin
                                        r_ph  <= 4'd0;
                                        r_ptr <= r_ptr + 16'd1;
                                    end else begin
                                        r_ph <= r_ph + 4'd1;
                                    end
                                end
                            end
                            K_RDBIT: begin
                                // Reads run one bit ahead of the packing.
                                if (r_ph <= 4'd7) begin
                                    r_ptr  <= r_ptr + 16'd1;
                                    r_bvld <= (r_ptr < cnt_w);
                                    if (r_ph != 4'd0) r_acc[3'(r_ph - 4'd1)] <= r_cq & r_bvld;
                                    r_ph <= r_ph + 4'd1;
                                end else if (r_ph == 4'd8) begin
                                    r_acc[7] <= r_cq & r_bvld;
                                    r_ph     <= 4'd9;
                                end else if (adv) begin
                                    r_acc <= '0;
                                    r_ph  <= 4'd0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Memories
    always_ff @(posedge i_clk) begin
        if (rx_fire && store) r_pdu_mem[r_fill[PW-1:0]] <= b;
        if (pr_en) r_pq <= r_pdu_mem[pr_addr];
    end

    always_ff @(posedge i_clk) begin
        if (hw_en) r_hold_mem[hw_addr] <= hw_data;
        if (hr_en) r_hq <= r_hold_mem[hr_addr];
    end

    always_ff @(posedge i_clk) begin
        if (cw_en) r_coil_mem[cw_addr] <= cw_data;
        if (cr_en) r_cq <= r_coil_mem[cr_addr];
    end

    // Byte packer and output register
    logic [63:0] pk_new;
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            pk_new[63-8*k -: 8] = (3'(k) == r_pkn) ? ebyte : r_pk[63-8*k -: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_pk  <= '0;
            r_pkn <= '0;
        end else begin
            if (emit && adv && flush) begin
                r_ov <= 1'b1;
            end else if (o_tx.valid && o_tx.ready) begin
                r_ov <= 1'b0;
            end
            if (emit && adv) begin
                if (flush) begin
                    r_oc    <= pk_new;
                    r_ocnt  <= {1'b0, r_pkn} + 4'd1;
                    r_olast <= last;
                    r_pk    <= '0;
                    r_pkn   <= '0;
                end else begin
                    r_pk  <= pk_new;
                    r_pkn <= r_pkn + 3'd1;
                end
            end
        end
    end

    assign o_tx.valid    = r_ov;
    assign o_tx.tx_chunk = r_oc;
    assign o_tx.tx_count = r_ocnt;
    assign o_tx.tx_last  = r_olast;

endmodule
